### src/lzss_pkg.sv
// Shared types and constants for the LZSS bitstream decoder.
// No dependencies; used by lzss_window, lzss_bitstream_decoder and the testbench.
package lzss_pkg;

	localparam int BYTE_W         = 8;
	localparam int LIT_TOKEN_BITS = 9;

	// Compressed-side item
	typedef struct packed {
		logic [BYTE_W-1:0] in_byte;
		logic              is_last;
	} in_item_t;

	// Decompressed-side item
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              run_last;
	} out_item_t;

	// Window port controls from the decode sequencer
	typedef struct packed {
		logic              push;
		logic              fetch;
		logic [BYTE_W-1:0] wr_data;
	} win_ctl_t;

endpackage

### src/lzss_bitstream_decoder.sv
// LZSS bitstream decoder top level: bit accumulator, token decode and copy sequencer.
// Depends on lzss_pkg and lzss_window.
//
//  channel  | direction | handshake             | payload
//  ---------+-----------+-----------------------+-----------------------------
//  comp     | in        | comp_valid/comp_stall | comp_data  (in_byte, is_last)
//  plain    | out       | plain_valid/plain_st. | plain_data (out_byte, run_last)
//
// A byte that is only held back is taken in IDLE; a literal token passes DECODE and LIT.
// A match passes DECODE and COPY_RD, then copies its length+MIN_MATCH bytes in COPY_WR,
// one per cycle while the output does not stall, reading the window RAM as it writes it;
// a distance of WINDOW_DEPTH or more adds a COPY_RD subtraction per window subtracted.
// Output stall holds the copy sequencer in place; no input is taken until an
// item's last result is in the output register. Reset is asynchronous; the
// window reads as zero until written, with no clearing pass.
module lzss_bitstream_decoder #(
	parameter int WINDOW_DEPTH = 4096,
	parameter int DIST_BITS    = 12,
	parameter int LEN_BITS     = 5,
	parameter int MIN_MATCH    = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 comp_valid,
	output logic                 comp_stall,
	input  lzss_pkg::in_item_t   comp_data,
	output logic                 plain_valid,
	input  logic                 plain_stall,
	output lzss_pkg::out_item_t  plain_data
);

	localparam int AW         = $clog2(WINDOW_DEPTH);
	localparam int MATCH_BITS = 1 + DIST_BITS + LEN_BITS;
	localparam int ACC_W      = MATCH_BITS + 7;
	localparam int CNTW       = $clog2(ACC_W + 1);
	localparam int RUNW       = LEN_BITS + 1;
	localparam int CW         = (DIST_BITS > AW) ? DIST_BITS + 1 : AW + 1;
	localparam int BW         = lzss_pkg::BYTE_W;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_LIT,
		ST_COPY_RD,
		ST_COPY_WR
	} state_t;

	state_t              state_q;
	logic [CNTW-1:0]     cnt_q;
	logic                held_v_q;
	logic                clear_q;
	logic                plain_valid_q;

	logic [ACC_W-1:0]    acc_q;
	logic [BW-1:0]       held_q;
	logic [BW-1:0]       lit_q;
	logic [DIST_BITS-1:0] back_q;
	logic [RUNW-1:0]     rem_q;
	lzss_pkg::out_item_t plain_q;

	logic                in_take;
	logic                slot_free;
	logic [3:0]          trail_k;
	logic [ACC_W-1:0]    acc_push_byte;
	logic [ACC_W-1:0]    acc_push_trail;
	logic [ACC_W-1:0]    sh_flag;
	logic [ACC_W-1:0]    sh_lit;
	logic [ACC_W-1:0]    sh_mat;
	logic                lit_ok;
	logic                mat_ok;
	logic                back_big;
	logic                load_lit;
	logic                load_copy;
	lzss_pkg::win_ctl_t  win_ctl;
	logic [BW-1:0]       win_rd_data;

	assign comp_stall  = (state_q != ST_IDLE);
	assign in_take     = comp_valid && !comp_stall;
	assign slot_free   = !plain_valid_q || !plain_stall;
	assign plain_valid = plain_valid_q;
	assign plain_data  = plain_q;

	// Number of data bits in the padded trailer byte
	always_comb begin
		if (comp_data.in_byte == '0) begin
			trail_k = 4'd8;
		end else if (comp_data.in_byte > 8'd9) begin
			trail_k = 4'd0;
		end else begin
			trail_k = 4'(8'd9 - comp_data.in_byte);
		end
	end

	// Accumulator after appending the held byte or the trailer's data bits
	assign acc_push_byte  = {acc_q[ACC_W-BW-1:0], held_q};
	assign acc_push_trail = ACC_W'((acc_q << trail_k) | ACC_W'(held_q >> (4'd8 - trail_k)));

	// Token fields, aligned from the top of the pending bits
	assign sh_flag = acc_q >> (cnt_q - CNTW'(1));
	assign sh_lit  = acc_q >> (cnt_q - CNTW'(lzss_pkg::LIT_TOKEN_BITS));
	assign sh_mat  = acc_q >> (cnt_q - CNTW'(MATCH_BITS));
	assign lit_ok  = (cnt_q != '0) && !sh_flag[0] &&
	                 (cnt_q >= CNTW'(lzss_pkg::LIT_TOKEN_BITS));
	assign mat_ok  = (cnt_q != '0) && sh_flag[0] && (cnt_q >= CNTW'(MATCH_BITS));

	assign back_big  = CW'(back_q) >= CW'(WINDOW_DEPTH);
	assign load_lit  = (state_q == ST_LIT) && slot_free;
	assign load_copy = (state_q == ST_COPY_WR) && slot_free;

	// Window port controls
	always_comb begin
		win_ctl.push    = load_lit || load_copy;
		win_ctl.wr_data = (state_q == ST_LIT) ? lit_q : win_rd_data;
		win_ctl.fetch   = ((state_q == ST_COPY_RD) && !back_big) ||
		                  (load_copy && (rem_q != '0));
	end

	lzss_window #(
		.DEPTH(WINDOW_DEPTH)
	) u_window (
		.clk     (clk),
		.arst_n  (arst_n),
		.ctl     (win_ctl),
		.rd_back (AW'(back_q)),
		.rd_data (win_rd_data)
	);

	// Sequencer state and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			cnt_q         <= '0;
			held_v_q      <= 1'b0;
			clear_q       <= 1'b0;
			plain_valid_q <= 1'b0;
		end else begin
			// Output register fills on a load, empties on a transfer
			if (load_lit || load_copy) begin
				plain_valid_q <= 1'b1;
			end else if (!plain_stall) begin
				plain_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_IDLE: begin
					if (in_take) begin
						if (!comp_data.is_last) begin
							held_v_q <= 1'b1;
							clear_q  <= 1'b0;
							if (held_v_q) begin
								cnt_q   <= cnt_q + CNTW'(8);
								state_q <= ST_DECODE;
							end
						end else begin
							held_v_q <= 1'b0;
							if (held_v_q && (trail_k != '0)) begin
								cnt_q   <= cnt_q + CNTW'(trail_k);
								clear_q <= 1'b1;
								state_q <= ST_DECODE;
							end else begin
								cnt_q <= '0;
							end
						end
					end
				end
				ST_DECODE: begin
					if (lit_ok) begin
						cnt_q   <= clear_q ? '0 : cnt_q - CNTW'(lzss_pkg::LIT_TOKEN_BITS);
						state_q <= ST_LIT;
					end else if (mat_ok) begin
						cnt_q   <= clear_q ? '0 : cnt_q - CNTW'(MATCH_BITS);
						state_q <= ST_COPY_RD;
					end else begin
						if (clear_q) begin
							cnt_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				ST_LIT: begin
					if (slot_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_COPY_RD: begin
					if (!back_big) begin
						state_q <= ST_COPY_WR;
					end
				end
				ST_COPY_WR: begin
					if (slot_free && (rem_q == '0)) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Payload registers: bits, token fields, copy count, output item
	always_ff @(posedge clk) begin
		if (in_take) begin
			if (!comp_data.is_last) begin
				held_q <= comp_data.in_byte;
				if (held_v_q) begin
					acc_q <= acc_push_byte;
				end
			end else if (held_v_q) begin
				acc_q <= acc_push_trail;
			end
		end
		if (state_q == ST_DECODE) begin
			lit_q  <= sh_lit[BW-1:0];
			back_q <= sh_mat[LEN_BITS+DIST_BITS-1:LEN_BITS];
			rem_q  <= RUNW'(sh_mat[LEN_BITS-1:0]) + RUNW'(MIN_MATCH - 1);
		end
		if ((state_q == ST_COPY_RD) && back_big) begin
			back_q <= DIST_BITS'(CW'(back_q) - CW'(WINDOW_DEPTH));
		end
		if (load_copy && (rem_q != '0)) begin
			rem_q <= rem_q - RUNW'(1);
		end
		if (load_lit) begin
			plain_q.out_byte <= lit_q;
			plain_q.run_last <= 1'b1;
		end else if (load_copy) begin
			plain_q.out_byte <= win_rd_data;
			plain_q.run_last <= (rem_q == '0);
		end
	end

	// Pending bits never exceed the accumulator
	a_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNTW'(ACC_W))
		else $error("bit count beyond accumulator width");

	// Between items fewer bits wait than any match token needs
	a_idle_partial: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (cnt_q < CNTW'(MATCH_BITS)))
		else $error("complete token left undecoded");

	// The final result of an item returns the sequencer to idle
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(load_lit || (load_copy && (rem_q == '0))) |=> (state_q == ST_IDLE))
		else $error("sequencer busy after final result");

	// The trailer leaves no pending bits behind
	a_trailer_clear: assert property (@(posedge clk) disable iff (!arst_n)
		((state_q == ST_DECODE) && clear_q) |=> (cnt_q == '0))
		else $error("pending bits kept after trailer");

endmodule

### src/lzss_window.sv
// History window: one synchronous RAM with a write pointer and fill tracking.
// Depends on lzss_pkg (win_ctl_t, BYTE_W).
module lzss_window #(
	parameter int DEPTH = 4096
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  lzss_pkg::win_ctl_t           ctl,
	input  logic [$clog2(DEPTH)-1:0]     rd_back,
	output logic [lzss_pkg::BYTE_W-1:0]  rd_data
);

	localparam int AW = $clog2(DEPTH);

	logic [lzss_pkg::BYTE_W-1:0] win_mem [DEPTH];

	logic [AW-1:0]               wptr_q;
	logic                        filled_q;
	logic [AW-1:0]               wptr_inc;
	logic [AW-1:0]               rd_base;
	logic [AW-1:0]               rd_addr;
	logic                        rd_fwd;
	logic                        rd_known;
	logic [lzss_pkg::BYTE_W-1:0] rd_raw_q;
	logic [lzss_pkg::BYTE_W-1:0] fwd_data_q;
	logic                        fwd_q;
	logic                        known_q;

	// Pointer after this cycle's write; reads are relative to it
	assign wptr_inc = (wptr_q == AW'(DEPTH - 1)) ? '0 : wptr_q + AW'(1);
	assign rd_base  = ctl.push ? wptr_inc : wptr_q;

	// Address distance back, wrapping around the window
	always_comb begin
		if (rd_base >= rd_back) begin
			rd_addr = rd_base - rd_back;
		end else begin
			rd_addr = AW'({1'b0, rd_base} + (AW + 1)'(DEPTH) - {1'b0, rd_back});
		end
	end

	// Read of the entry written in this same cycle takes the new byte
	assign rd_fwd   = ctl.push && (rd_addr == wptr_q);
	// Entries are written in order from zero, so anything below the pointer is live
	assign rd_known = filled_q || (rd_addr < wptr_q) || rd_fwd;

	// Pointer and fill state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q   <= '0;
			filled_q <= 1'b0;
		end else if (ctl.push) begin
			wptr_q <= wptr_inc;
			if (wptr_q == AW'(DEPTH - 1)) begin
				filled_q <= 1'b1;
			end
		end
	end

	// RAM array, one write and one registered read per cycle
	always_ff @(posedge clk) begin
		if (ctl.push) begin
			win_mem[wptr_q] <= ctl.wr_data;
		end
		if (ctl.fetch) begin
			rd_raw_q   <= win_mem[rd_addr];
			fwd_data_q <= ctl.wr_data;
			fwd_q      <= rd_fwd;
			known_q    <= rd_known;
		end
	end

	// Unwritten entries read as zero
	assign rd_data = !known_q ? '0 : (fwd_q ? fwd_data_q : rd_raw_q);

endmodule

### tb/lzss_bitstream_decoder_tb.sv
// Self-checking testbench for lzss_bitstream_decoder: directed, then random LZSS and noise streams.
// A behavioral decoder predicts the bytes of untyped rows. Depends on lzss_pkg and the RTL only.
module lzss_bitstream_decoder_tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int WIN_DEPTH        = 4096;
	localparam int DIST_W           = 12;
	localparam int LEN_W            = 5;
	localparam int MIN_MATCH        = 4;
	localparam int MATCH_TOKEN_BITS = 1 + DIST_W + LEN_W;
	localparam int TRAILER_SPAN     = 9;   // count byte = padding bits + 1
	localparam int RANDOM_ITEMS     = 384;
	localparam int IDLE_LIMIT       = 2000;
	localparam int DRAIN_CYCLES     = 48;

	// Directed row: expectation is typed in only where typed is set
	typedef struct packed {
		lzss_pkg::in_item_t item;
		logic               typed;
		logic [5:0]         exp_n;
		logic [7:0]         exp_val;
	} dir_row_t;

	localparam int DIR_N = 26;
	localparam dir_row_t DIR_ROWS [DIR_N] = '{
		// distance zero right after reset, longest match: 35 zeros
		'{'{8'h80, 1'b0}, 1'b1, 6'd0,  8'h00},
		'{'{8'h07, 1'b0}, 1'b1, 6'd0,  8'h00},
		'{'{8'hC0, 1'b0}, 1'b1, 6'd0,  8'h00},
		'{'{8'h07, 1'b1}, 1'b1, 6'd35, 8'h00},
		// literal 0xFF, then literal 0x00 completed by the trailer
		'{'{8'h7F, 1'b0}, 1'b1, 6'd0,  8'h00},
		'{'{8'h80, 1'b0}, 1'b1, 6'd0,  8'h00},
		'{'{8'h00, 1'b0}, 1'b1, 6'd1,  8'hFF},
		'{'{8'h07, 1'b1}, 1'b1, 6'd1,  8'h00},
		// literal 0xA5, then an overlapping copy at distance one
		'{'{8'h52, 1'b0}, 1'b1, 6'd0,  8'h00},
		'{'{8'hC0, 1'b0}, 1'b1, 6'd0,  8'h00},
		'{'{8'h07, 1'b0}, 1'b1, 6'd1,  8'hA5},
		'{'{8'hE0, 1'b0}, 1'b1, 6'd0,  8'h00},
		'{'{8'h06, 1'b1}, 1'b1, 6'd35, 8'hA5},
		// trailer with nothing held
		'{'{8'h03, 1'b1}, 1'b0, 6'd0,  8'h00},
		// trailer count zero: full eight data bits
		'{'{8'h00, 1'b0}, 1'b0, 6'd0,  8'h00},
		'{'{8'hAA, 1'b0}, 1'b0, 6'd0,  8'h00},
		'{'{8'h00, 1'b1}, 1'b0, 6'd0,  8'h00},
		// trailer count above nine
		'{'{8'h00, 1'b0}, 1'b0, 6'd0,  8'h00},
		'{'{8'hFF, 1'b0}, 1'b0, 6'd0,  8'h00},
		'{'{8'h0A, 1'b1}, 1'b0, 6'd0,  8'h00},
		'{'{8'hFF, 1'b0}, 1'b0, 6'd0,  8'h00},
		'{'{8'hFF, 1'b1}, 1'b0, 6'd0,  8'h00},
		// largest distance, shortest match
		'{'{8'hFF, 1'b0}, 1'b0, 6'd0,  8'h00},
		'{'{8'hF8, 1'b0}, 1'b0, 6'd0,  8'h00},
		'{'{8'h00, 1'b0}, 1'b0, 6'd0,  8'h00},
		'{'{8'h07, 1'b1}, 1'b0, 6'd0,  8'h00}
	};

	logic                clk;
	logic                arst_n      = 1'b0;
	logic                comp_valid  = 1'b0;
	logic                comp_stall;
	lzss_pkg::in_item_t  comp_data   = '0;
	logic                plain_valid;
	logic                plain_stall = 1'b0;
	lzss_pkg::out_item_t plain_data;

	lzss_bitstream_decoder DUT (
		.clk         (clk),
		.arst_n      (arst_n),
		.comp_valid  (comp_valid),
		.comp_stall  (comp_stall),
		.comp_data   (comp_data),
		.plain_valid (plain_valid),
		.plain_stall (plain_stall),
		.plain_data  (plain_data)
	);

	always begin
		clk = 1'b1;
		#4;
		clk = 1'b0;
		#4;
	end

	// Behavioral decoder state
	logic [7:0]  hist [WIN_DEPTH];
	logic [11:0] wr_ptr;
	logic [31:0] acc;
	int          acc_bits;
	logic [7:0]  held_byte;
	bit          held_valid;

	lzss_pkg::out_item_t plain_expect_q [$];
	lzss_pkg::out_item_t pred_out [$];
	lzss_pkg::in_item_t  stream_q [$];

	int mismatch_cnt   = 0;
	int sent_cnt       = 0;
	int send_idle_pct  = 37;
	int recv_stall_pct = 77;
	int total_items    = DIR_N + RANDOM_ITEMS;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		mismatch_cnt++;
	endtask

	function automatic void clear_decoder();
		foreach (hist[i])
			hist[i] = 8'h00;
		wr_ptr     = '0;
		acc        = '0;
		acc_bits   = 0;
		held_byte  = '0;
		held_valid = 1'b0;
	endfunction

	function automatic void emit_byte(input logic [7:0] b);
		lzss_pkg::out_item_t res;
		res.out_byte = b;
		res.run_last = 1'b0;
		pred_out.push_back(res);
		hist[wr_ptr] = b;
		wr_ptr       = wr_ptr + 12'd1;
	endfunction

	function automatic void push_bits(input logic [7:0] val, input int nbits);
		acc      = (acc << nbits) | ({24'd0, val} & ((32'd1 << nbits) - 32'd1));
		acc_bits = acc_bits + nbits;
	endfunction

	// Decode every complete token in the accumulator
	function automatic void drain_tokens();
		logic        flag;
		logic [11:0] dist_v;
		logic [11:0] rd;
		logic [4:0]  len;
		int          i;
		while (acc_bits > 0) begin
			flag = acc[acc_bits-1];
			if (!flag && acc_bits >= lzss_pkg::LIT_TOKEN_BITS) begin
				acc_bits = acc_bits - lzss_pkg::LIT_TOKEN_BITS;
				emit_byte(8'(acc >> acc_bits));
			end else if (flag && acc_bits >= MATCH_TOKEN_BITS) begin
				dist_v   = 12'(acc >> (acc_bits - 1 - DIST_W));
				len      = 5'(acc >> (acc_bits - MATCH_TOKEN_BITS));
				acc_bits = acc_bits - MATCH_TOKEN_BITS;
				for (i = 0; i < int'(len) + MIN_MATCH; i++) begin
					rd = wr_ptr - dist_v;
					emit_byte(hist[rd]);
				end
			end else begin
				break;
			end
			acc = acc & ((32'd1 << acc_bits) - 32'd1);
		end
	endfunction

	// Predict the results of one accepted transfer into pred_out
	function automatic void decode_item(input lzss_pkg::in_item_t it);
		int k;
		pred_out.delete();
		if (!it.is_last) begin
			if (held_valid) begin
				push_bits(held_byte, 8);
				drain_tokens();
			end
			held_byte  = it.in_byte;
			held_valid = 1'b1;
		end else begin
			if (held_valid) begin
				if (it.in_byte == 8'd0)
					k = 8;
				else if (it.in_byte > 8'(TRAILER_SPAN))
					k = 0;
				else
					k = TRAILER_SPAN - int'(it.in_byte);
				if (k != 0) begin
					push_bits(held_byte >> (8 - k), k);
					drain_tokens();
				end
			end
			acc        = '0;
			acc_bits   = 0;
			held_byte  = '0;
			held_valid = 1'b0;
		end
		if (pred_out.size() > 0)
			pred_out[pred_out.size()-1].run_last = 1'b1;
	endfunction

	// Drive one compressed byte and record what it must produce
	task automatic send_item(input lzss_pkg::in_item_t it, input bit typed, input int exp_n,
			input logic [7:0] exp_val);
		lzss_pkg::out_item_t res;
		int                  i;
		if (sent_cnt < total_items / 3) begin
			send_idle_pct  = 37;
			recv_stall_pct = 77;
		end else if (sent_cnt < 2 * total_items / 3) begin
			send_idle_pct  = 77;
			recv_stall_pct = 37;
		end else begin
			send_idle_pct  = 0;
			recv_stall_pct = 0;
		end
		while (int'($urandom_range(99)) < send_idle_pct) begin
			comp_valid <= 1'b0;
			@(posedge clk);
		end
		comp_valid <= 1'b1;
		comp_data  <= it;
		@(posedge clk);
		while (comp_stall)
			@(posedge clk);
		sent_cnt++;
		decode_item(it);
		if (typed) begin
			for (i = 0; i < exp_n; i++) begin
				res.out_byte = exp_val;
				res.run_last = (i == exp_n - 1);
				plain_expect_q.push_back(res);
			end
		end else begin
			foreach (pred_out[j])
				plain_expect_q.push_back(pred_out[j]);
		end
	endtask

	// Well-formed stream of random tokens plus trailer; sometimes a bad count byte
	task automatic build_clean_stream();
		bit                 bits_q [$];
		int                 n_tok;
		int                 t;
		int                 b;
		int                 pad;
		logic [11:0]        dist_v;
		logic [4:0]         len;
		logic [7:0]         lit;
		logic [7:0]         byte_v;
		lzss_pkg::in_item_t it;
		stream_q.delete();
		n_tok = $urandom_range(1, 6);
		for (t = 0; t < n_tok; t++) begin
			if ($urandom_range(1) == 1) begin
				lit = 8'($urandom);
				bits_q.push_back(1'b0);
				for (b = 7; b >= 0; b--)
					bits_q.push_back(lit[b]);
			end else begin
				case ($urandom_range(3))
					0: dist_v = 12'($urandom_range(1, 8));
					1: dist_v = 12'($urandom_range(1, 64));
					2: dist_v = 12'($urandom);
					default: dist_v = ($urandom_range(1) == 1) ? '1 : '0;
				endcase
				len = 5'($urandom);
				bits_q.push_back(1'b1);
				for (b = DIST_W - 1; b >= 0; b--)
					bits_q.push_back(dist_v[b]);
				for (b = LEN_W - 1; b >= 0; b--)
					bits_q.push_back(len[b]);
			end
		end
		pad = (8 - bits_q.size() % 8) % 8;
		for (b = 0; b < pad; b++)
			bits_q.push_back(1'($urandom_range(1)));
		for (t = 0; t < bits_q.size() / 8; t++) begin
			for (b = 0; b < 8; b++)
				byte_v[7-b] = bits_q[8*t+b];
			it.in_byte = byte_v;
			it.is_last = 1'b0;
			stream_q.push_back(it);
		end
		it.is_last = 1'b1;
		if ($urandom_range(7) == 0)
			it.in_byte = 8'($urandom);
		else if (pad == 0)
			it.in_byte = 8'($urandom_range(1));
		else
			it.in_byte = 8'(pad + 1);
		stream_q.push_back(it);
	endtask

	// Unstructured bytes with stray end marks
	task automatic build_noise();
		int                 n;
		int                 i;
		lzss_pkg::in_item_t it;
		stream_q.delete();
		n = $urandom_range(1, 6);
		for (i = 0; i < n; i++) begin
			it.in_byte = 8'($urandom);
			it.is_last = ($urandom_range(4) == 0);
			stream_q.push_back(it);
		end
	endtask

	// Output side: random stall, compare each transfer with the oldest expectation
	always @(posedge clk) begin : plain_check
		lzss_pkg::out_item_t want;
		if (arst_n && plain_valid && !plain_stall) begin
			if (plain_expect_q.size() == 0) begin
				report_mismatch($sformatf("unexpected output byte %02h", plain_data.out_byte));
			end else begin
				want = plain_expect_q.pop_front();
				if (plain_data.out_byte !== want.out_byte)
					report_mismatch($sformatf("out_byte %02h, want %02h",
						plain_data.out_byte, want.out_byte));
				if (plain_data.run_last !== want.run_last)
					report_mismatch($sformatf("run_last %0b, want %0b (byte %02h)",
						plain_data.run_last, want.run_last, want.out_byte));
			end
		end
		plain_stall <= (int'($urandom_range(99)) < recv_stall_pct);
	end

	// Watchdog on cycles without any transfer
	int idle_cycles = 0;
	always @(posedge clk) begin
		if (arst_n) begin
			if ((comp_valid && !comp_stall) || (plain_valid && !plain_stall))
				idle_cycles <= 0;
			else
				idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("Timeout: no transfer for %0d cycles", IDLE_LIMIT);
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin : stimulus
		int i;
		clear_decoder();
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (i = 0; i < DIR_N; i++)
			send_item(DIR_ROWS[i].item, DIR_ROWS[i].typed, int'(DIR_ROWS[i].exp_n),
				DIR_ROWS[i].exp_val);

		while (sent_cnt < total_items) begin
			if ($urandom_range(9) < 8)
				build_clean_stream();
			else
				build_noise();
			foreach (stream_q[j])
				send_item(stream_q[j], 1'b0, 0, 8'h00);
		end
		comp_valid <= 1'b0;

		while (plain_expect_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (mismatch_cnt == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

### filelist.f
src/lzss_pkg.sv
src/lzss_window.sv
src/lzss_bitstream_decoder.sv
tb/lzss_bitstream_decoder_tb.sv
